FILE: design/ibau_pkg.sv
`timescale 1ns / 1ps

package ibau_pkg;

    // index lists are named by a 4-bit index block number
    localparam int NUM_LISTS = 16;

    // parameter defaults for the top level
    localparam int DEF_NUM_BLOCKS   = 16;
    localparam int DEF_MAX_FILE_LEN = 16;

    // field widths
    localparam int IB_W      = 4;
    localparam int CHAR_W    = 8;
    localparam int POS_W     = 4;
    localparam int STATUS_W  = 3;
    localparam int BLK_OUT_W = 4;

    // stream widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // request kinds
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_REJECT   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_TOO_LONG = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd4;

endpackage

FILE: design/ibau_free_search.sv
`timescale 1ns / 1ps

// finds the lowest free data block at or above the search pointer; every block
// below the pointer is in use, and above the index range only blocks below the
// pointer can be in use, so a 16-bit priority encoder covers the search
module ibau_free_search #(
    parameter int NUM_BLOCKS = ibau_pkg::DEF_NUM_BLOCKS,
    parameter int NF_W       = $clog2(NUM_BLOCKS + 1),
    parameter int BLK_W      = $clog2(NUM_BLOCKS)
) (
    input  logic [ibau_pkg::NUM_LISTS-1:0] used,
    input  logic [NF_W-1:0]                next_free,
    output logic                           found,
    output logic [BLK_W-1:0]               blk
);

    logic [NF_W-1:0] hi_blk;
    logic            hi_ok;

    // first free block above the index range
    always_comb begin
        hi_blk = '0;
        hi_ok  = 1'b0;
        if (NUM_BLOCKS > ibau_pkg::NUM_LISTS) begin
            hi_blk = (int'(next_free) > ibau_pkg::NUM_LISTS) ? next_free
                                                              : NF_W'(ibau_pkg::NUM_LISTS);
            hi_ok  = int'(hi_blk) < NUM_BLOCKS;
        end
    end

    // priority encode over the index range, lowest block wins
    always_comb begin
        found = hi_ok;
        blk   = BLK_W'(hi_blk);
        for (int i = ibau_pkg::NUM_LISTS - 1; i >= 0; i--) begin
            if (i < NUM_BLOCKS && i >= int'(next_free) && !used[i]) begin
                found = 1'b1;
                blk   = BLK_W'(i);
            end
        end
    end

endmodule

FILE: design/ibau_list_mem.sv
`timescale 1ns / 1ps

// index list storage: one memory row per list entry, plus a fill count per list
// so that entries never written read as empty without a clearing pass
module ibau_list_mem #(
    parameter int MAX_FILE_LEN = ibau_pkg::DEF_MAX_FILE_LEN,
    parameter int BLK_W        = 4,
    parameter int POS_IW       = $clog2(MAX_FILE_LEN),
    parameter int LEN_W        = $clog2(MAX_FILE_LEN + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [ibau_pkg::IB_W-1:0]  wr_list,
    input  logic [POS_IW-1:0]          wr_pos,
    input  logic [BLK_W-1:0]           wr_blk,
    input  logic                       rd_en,
    input  logic [ibau_pkg::IB_W-1:0]  rd_list,
    input  logic [POS_IW-1:0]          rd_pos,
    output logic [BLK_W-1:0]           rd_blk,
    output logic [LEN_W-1:0]           rd_fill
);

    localparam int DEPTH = ibau_pkg::NUM_LISTS * (2 ** POS_IW);

    logic [BLK_W-1:0] mem [DEPTH];
    logic [LEN_W-1:0] fill_reg [ibau_pkg::NUM_LISTS];

    // entry write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[{wr_list, wr_pos}] <= wr_blk;
        end
        if (rd_en) begin
            rd_blk <= mem[{rd_list, rd_pos}];
        end
    end

    // fill count per list, bumped on each appended entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ibau_pkg::NUM_LISTS; i++) begin
                fill_reg[i] <= '0;
            end
        end else if (wr_en) begin
            fill_reg[wr_list] <= fill_reg[wr_list] + LEN_W'(1);
        end
    end

    assign rd_fill = fill_reg[rd_list];

endmodule

FILE: design/ibau_block_mem.sv
`timescale 1ns / 1ps

// data block storage, one character per block
module ibau_block_mem #(
    parameter int NUM_BLOCKS = ibau_pkg::DEF_NUM_BLOCKS,
    parameter int BLK_W      = $clog2(NUM_BLOCKS)
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [BLK_W-1:0]              wr_blk,
    input  logic [ibau_pkg::CHAR_W-1:0]   wr_char,
    input  logic                          rd_en,
    input  logic [BLK_W-1:0]              rd_blk,
    output logic [ibau_pkg::CHAR_W-1:0]   rd_char
);

    logic [ibau_pkg::CHAR_W-1:0] mem [NUM_BLOCKS];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_blk] <= wr_char;
        end
        if (rd_en) begin
            rd_char <= mem[rd_blk];
        end
    end

endmodule

FILE: design/indexed_block_allocator_unit.sv
// Indexed block allocator.
// Input transfers on s_*: a write carries one file character; the first
// character of a file (tuser[1]) names its index block, which must be free.
// Each accepted character takes the lowest free data block at or above the
// search pointer and is appended to the file's index list. A read (tuser[0])
// returns the block number and character at one position of an index list.
// Every input transfer yields exactly one result transfer on m_*.
// A write result is in the output register in the cycle after the transfer;
// a read passes the index list memory, then the block memory, both with
// registered read data, before its result is loaded.
// Throughput: one write every cycle while the receiver keeps up; an item is
// taken only while no read is in progress and the output register is empty
// or being drained, so a stalled m_tready holds off s_tready.
// Reset (aresetn low, synchronous) frees all blocks, empties all index
// lists, closes any open file and sets the search pointer to block 1;
// no clearing pass is needed.
`timescale 1ns / 1ps

module indexed_block_allocator_unit #(
    parameter int NUM_BLOCKS   = ibau_pkg::DEF_NUM_BLOCKS,
    parameter int MAX_FILE_LEN = ibau_pkg::DEF_MAX_FILE_LEN
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // index_block[3:0], char_in[11:4], position[15:12]
    input  logic [ibau_pkg::S_TDATA_W-1:0]   s_tdata,
    // func[0], first_char[1]
    input  logic [ibau_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[2:0], block_number[6:3], char_out[14:7], zero[15]
    output logic [ibau_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int BLK_W  = $clog2(NUM_BLOCKS);
    localparam int NF_W   = $clog2(NUM_BLOCKS + 1);
    localparam int LEN_W  = $clog2(MAX_FILE_LEN + 1);
    localparam int POS_IW = $clog2(MAX_FILE_LEN);
    localparam int BLK_XW = (BLK_W > ibau_pkg::BLK_OUT_W) ? BLK_W : ibau_pkg::BLK_OUT_W;
    localparam int POS_XW = (POS_IW > ibau_pkg::POS_W) ? POS_IW : ibau_pkg::POS_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LIST  = 2'd1;
    localparam logic [1:0] ST_BLOCK = 2'd2;

    // input fields
    logic                          in_func;
    logic                          in_first;
    logic [ibau_pkg::IB_W-1:0]     in_ib;
    logic [ibau_pkg::CHAR_W-1:0]   in_char;
    logic [ibau_pkg::POS_W-1:0]    in_pos;
    logic [POS_XW-1:0]             in_pos_x;

    assign in_func  = s_tuser[0];
    assign in_first = s_tuser[1];
    assign in_ib    = s_tdata[3:0];
    assign in_char  = s_tdata[11:4];
    assign in_pos   = s_tdata[15:12];
    assign in_pos_x = POS_XW'(in_pos);

    // control state
    logic [1:0]                      state_reg, state_next;
    logic [ibau_pkg::NUM_LISTS-1:0]  idx_used_reg, idx_used_next;
    logic [NF_W-1:0]                 next_free_reg, next_free_next;
    logic [ibau_pkg::IB_W-1:0]       file_reg, file_next;
    logic [LEN_W-1:0]                len_reg, len_next;
    logic                            rej_reg, rej_next;
    logic                            rd_ok_reg, rd_ok_next;

    // output register
    logic                            m_valid_reg, m_valid_next;
    logic [ibau_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [ibau_pkg::BLK_OUT_W-1:0]  blk_out_reg, blk_out_next;
    logic [ibau_pkg::CHAR_W-1:0]     char_out_reg, char_out_next;

    logic                            out_free;
    logic                            s_fire;
    logic                            wr_acc;
    logic                            rd_acc;
    logic                            ld_rd;

    // write decision
    logic                            index_ok;
    logic                            ib_used;
    logic                            open_ok;
    logic                            go;
    logic [LEN_W-1:0]                len_base;
    logic [ibau_pkg::NUM_LISTS-1:0]  search_used;
    logic                            found;
    logic [BLK_W-1:0]                found_blk;
    logic                            alloc_en;
    logic [ibau_pkg::STATUS_W-1:0]   wr_status;
    logic [BLK_XW-1:0]               wr_blk_x;

    // read path
    logic [BLK_W-1:0]                list_blk;
    logic [LEN_W-1:0]                list_fill;
    logic [ibau_pkg::CHAR_W-1:0]     blk_char;
    logic                            rd_valid;
    logic                            rd_hit;
    logic [BLK_XW-1:0]               rd_blk_x;
    logic [LEN_W-1:0]                len_base_x;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_tvalid && s_tready;
    assign wr_acc   = s_fire && (in_func == ibau_pkg::FUNC_WRITE);
    assign rd_acc   = s_fire && (in_func == ibau_pkg::FUNC_READ);
    assign ld_rd    = (state_reg == ST_BLOCK) && out_free;

    // a block is in use if it lies below the search pointer or holds an index
    assign index_ok = (in_ib != '0) && (int'(in_ib) < NUM_BLOCKS);
    assign ib_used  = idx_used_reg[in_ib] || (int'(in_ib) < int'(next_free_reg));
    assign open_ok  = index_ok && !ib_used;
    assign len_base = in_first ? '0 : len_reg;

    ibau_free_search #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .NF_W       (NF_W),
        .BLK_W      (BLK_W)
    ) u_search (
        .used      (search_used),
        .next_free (next_free_reg),
        .found     (found),
        .blk       (found_blk)
    );

    // write item: open or continue a file, then allocate one block
    always_comb begin
        file_next      = file_reg;
        rej_next       = rej_reg;
        len_next       = len_reg;
        next_free_next = next_free_reg;
        idx_used_next  = idx_used_reg;
        search_used    = idx_used_reg;
        wr_status      = ibau_pkg::STAT_OK;
        alloc_en       = 1'b0;
        go             = 1'b0;
        if (in_first) begin
            len_next = '0;
            if (!open_ok) begin
                file_next = index_ok ? in_ib : '0;
                rej_next  = 1'b1;
                wr_status = ibau_pkg::STAT_REJECT;
            end else begin
                file_next            = in_ib;
                rej_next             = 1'b0;
                idx_used_next[in_ib] = 1'b1;
                search_used[in_ib]   = 1'b1;
                go                   = 1'b1;
            end
        end else if (file_reg == '0 || rej_reg) begin
            wr_status = ibau_pkg::STAT_REJECT;
        end else begin
            go = 1'b1;
        end
        if (go) begin
            if (int'(len_base) >= MAX_FILE_LEN) begin
                wr_status = ibau_pkg::STAT_TOO_LONG;
            end else if (!found) begin
                next_free_next = NF_W'(NUM_BLOCKS);
                wr_status      = ibau_pkg::STAT_FULL;
            end else begin
                alloc_en       = 1'b1;
                next_free_next = NF_W'(found_blk) + NF_W'(1);
                len_next       = len_base + LEN_W'(1);
            end
        end
    end

    assign wr_blk_x   = alloc_en ? BLK_XW'(found_blk) : '0;
    assign len_base_x = len_base;

    // read item: validity of the list position is known at the transfer
    assign rd_valid = index_ok && (int'(in_pos) < MAX_FILE_LEN)
                      && (int'(in_pos) < int'(list_fill));

    ibau_list_mem #(
        .MAX_FILE_LEN (MAX_FILE_LEN),
        .BLK_W        (BLK_W),
        .POS_IW       (POS_IW),
        .LEN_W        (LEN_W)
    ) u_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_acc && alloc_en),
        .wr_list (file_next),
        .wr_pos  (len_base_x[POS_IW-1:0]),
        .wr_blk  (found_blk),
        .rd_en   (rd_acc),
        .rd_list (in_ib),
        .rd_pos  (in_pos_x[POS_IW-1:0]),
        .rd_blk  (list_blk),
        .rd_fill (list_fill)
    );

    ibau_block_mem #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .BLK_W      (BLK_W)
    ) u_block (
        .aclk    (aclk),
        .wr_en   (wr_acc && alloc_en),
        .wr_blk  (found_blk),
        .wr_char (in_char),
        .rd_en   (state_reg == ST_LIST),
        .rd_blk  (list_blk),
        .rd_char (blk_char)
    );

    assign rd_hit   = rd_ok_reg && (list_blk != '0);
    assign rd_blk_x = BLK_XW'(list_blk);

    // sequencer for the two memory reads of a read item
    always_comb begin
        state_next = state_reg;
        rd_ok_next = rd_ok_reg;
        case (state_reg)
            ST_IDLE: begin
                if (rd_acc) begin
                    state_next = ST_LIST;
                    rd_ok_next = rd_valid;
                end
            end
            ST_LIST: begin
                state_next = ST_BLOCK;
            end
            ST_BLOCK: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register load and drain
    always_comb begin
        m_valid_next  = m_valid_reg && !m_tready;
        status_next   = status_reg;
        blk_out_next  = blk_out_reg;
        char_out_next = char_out_reg;
        if (wr_acc) begin
            m_valid_next  = 1'b1;
            status_next   = wr_status;
            blk_out_next  = wr_blk_x[ibau_pkg::BLK_OUT_W-1:0];
            char_out_next = '0;
        end else if (ld_rd) begin
            m_valid_next = 1'b1;
            if (rd_hit) begin
                status_next   = ibau_pkg::STAT_OK;
                blk_out_next  = rd_blk_x[ibau_pkg::BLK_OUT_W-1:0];
                char_out_next = blk_char;
            end else begin
                status_next   = ibau_pkg::STAT_EMPTY;
                blk_out_next  = '0;
                char_out_next = '0;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_used_reg  <= '0;
            next_free_reg <= NF_W'(1);
            file_reg      <= '0;
            len_reg       <= '0;
            rej_reg       <= 1'b0;
            rd_ok_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_ok_reg   <= rd_ok_next;
            m_valid_reg <= m_valid_next;
            if (wr_acc) begin
                idx_used_reg  <= idx_used_next;
                next_free_reg <= next_free_next;
                file_reg      <= file_next;
                len_reg       <= len_next;
                rej_reg       <= rej_next;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        status_reg   <= status_next;
        blk_out_reg  <= blk_out_next;
        char_out_reg <= char_out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, char_out_reg, blk_out_reg, status_reg};

    // a successful allocation moves the search pointer just past the new block
    a_alloc_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_acc && alloc_en) |=> (next_free_reg == NF_W'($past(found_blk)) + NF_W'(1)))
        else $error("search pointer not advanced past allocated block");

    // a read walks list memory then block memory before its result
    a_read_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_acc |=> (state_reg == ST_LIST) ##1 (state_reg == ST_BLOCK))
        else $error("read sequencing broken");

    // the search pointer stays within the block range
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (next_free_reg != '0) && (int'(next_free_reg) <= NUM_BLOCKS))
        else $error("search pointer out of range");

    // the open file never grows past its limit
    a_len_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(len_reg) <= MAX_FILE_LEN)
        else $error("file length beyond limit");

    // a write result lands in the output register on the next cycle
    a_wr_result: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_acc |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("write result missing");

endmodule

FILE: sim/indexed_block_allocator_unit_test.sv
`timescale 1ns / 1ps

module indexed_block_allocator_unit_test;

    import ibau_pkg::*;

    localparam int NB        = DEF_NUM_BLOCKS;
    localparam int MAX_LEN   = DEF_MAX_FILE_LEN;
    localparam int RAND_REQS = 550;
    localparam int DRAIN     = 20;
    localparam int LIMIT     = 200000;

    typedef struct packed {
        logic                func;
        logic [IB_W-1:0]     index_block;
        logic [CHAR_W-1:0]   char_in;
        logic                first_char;
        logic [POS_W-1:0]    position;
    } file_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [BLK_OUT_W-1:0] block_number;
        logic [CHAR_W-1:0]    char_out;
    } file_reply_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    indexed_block_allocator_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    file_req_t   request_queue[$];
    file_reply_t expected_replies[$];
    int          n_errors = 0;
    int          cycle_count = 0;

    // allocator state as the block should hold it
    bit               used_map[NB];
    int               next_free = 1;
    logic [IB_W-1:0]  index_lists[NUM_LISTS][MAX_LEN];
    logic [CHAR_W-1:0] block_store[NB];
    int               cur_file = 0;
    int               cur_len = 0;
    bit               cur_rejected = 1'b0;

    initial begin
        foreach (used_map[i]) used_map[i] = 1'b0;
        foreach (index_lists[i, j]) index_lists[i][j] = '0;
        foreach (block_store[i]) block_store[i] = '0;
    end

    function automatic bit index_usable(int ib);
        return ib != 0 && ib < NUM_LISTS && ib < NB;
    endfunction

    // allocate a block for one file character, or look up one index list entry
    function automatic file_reply_t alloc_lookup(file_req_t rq);
        file_reply_t rep;
        int          ib;
        int          b;
        rep = '{status: STAT_OK, block_number: '0, char_out: '0};
        ib = rq.index_block;
        if (rq.func == FUNC_READ) begin
            if (!index_usable(ib) || rq.position >= MAX_LEN) begin
                rep.status = STAT_EMPTY;
                return rep;
            end
            b = index_lists[ib][rq.position];
            if (b == 0 || b >= NB) begin
                rep.status = STAT_EMPTY;
                return rep;
            end
            rep.block_number = b[BLK_OUT_W-1:0];
            rep.char_out = block_store[b];
            return rep;
        end
        // write: opening a file claims its index block
        if (rq.first_char) begin
            cur_len = 0;
            if (!index_usable(ib) || used_map[ib]) begin
                cur_file = index_usable(ib) ? ib : 0;
                cur_rejected = 1'b1;
                rep.status = STAT_REJECT;
                return rep;
            end
            used_map[ib] = 1'b1;
            cur_file = ib;
            cur_rejected = 1'b0;
        end else if (cur_file == 0 || cur_rejected) begin
            rep.status = STAT_REJECT;
            return rep;
        end
        if (cur_len >= MAX_LEN) begin
            rep.status = STAT_TOO_LONG;
            return rep;
        end
        // search upward, busy blocks do not count against the file length
        b = next_free;
        while (b < NB && used_map[b]) b++;
        if (b >= NB) begin
            next_free = NB;
            rep.status = STAT_FULL;
            return rep;
        end
        used_map[b] = 1'b1;
        block_store[b] = rq.char_in;
        index_lists[cur_file % NUM_LISTS][cur_len] = b[IB_W-1:0];
        cur_len++;
        next_free = b + 1;
        rep.block_number = b[BLK_OUT_W-1:0];
        return rep;
    endfunction

    function automatic void push_write(int ib, int ch, bit first);
        file_req_t rq;
        rq.func = FUNC_WRITE;
        rq.index_block = ib[IB_W-1:0];
        rq.char_in = ch[CHAR_W-1:0];
        rq.first_char = first;
        rq.position = POS_W'($urandom_range(0, 15));
        request_queue.push_back(rq);
    endfunction

    function automatic void push_read(int ib, int pos);
        file_req_t rq;
        rq.func = FUNC_READ;
        rq.index_block = ib[IB_W-1:0];
        rq.char_in = CHAR_W'($urandom_range(0, 255));
        rq.first_char = 1'($urandom_range(0, 1));
        rq.position = pos[POS_W-1:0];
        request_queue.push_back(rq);
    endfunction

    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 9);
    endfunction

    // input side: present queued requests with random gaps between transfers
    int send_gap = 0;
    bit send_burst = 1'b0;

    always @(posedge aclk) begin
        file_req_t rq;
        logic      nxt_valid;
        nxt_valid = s_tvalid;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(alloc_lookup({s_tuser[0], s_tdata[3:0],
                    s_tdata[11:4], s_tuser[1], s_tdata[15:12]}));
                if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
                send_gap = draw_gap(send_burst);
                nxt_valid = 1'b0;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    nxt_valid = 1'b0;
                end else if (request_queue.size() > 0) begin
                    rq = request_queue.pop_front();
                    s_tdata <= {rq.position, rq.char_in, rq.index_block};
                    s_tuser <= {rq.first_char, rq.func};
                    nxt_valid = 1'b1;
                end else begin
                    nxt_valid = 1'b0;
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // result side: random stalls, compare each transfer with the oldest expectation
    int recv_stall = 0;
    bit recv_burst = 1'b0;

    always @(posedge aclk) begin
        file_reply_t exp_rep;
        file_reply_t got;
        logic        nxt_ready;
        nxt_ready = m_tready;
        if (!aresetn) begin
            nxt_ready = 1'b0;
        end else if (m_tvalid && m_tready) begin
            got = '{status: m_tdata[2:0], block_number: m_tdata[6:3],
                    char_out: m_tdata[14:7]};
            if (expected_replies.size() == 0) begin
                $error("unexpected result transfer: status %0d block %0d char %0h",
                       got.status, got.block_number, got.char_out);
                n_errors++;
            end else begin
                exp_rep = expected_replies.pop_front();
                if (got.status !== exp_rep.status) begin
                    $error("status: expected %0d, got %0d", exp_rep.status, got.status);
                    n_errors++;
                end
                if (got.block_number !== exp_rep.block_number) begin
                    $error("block_number: expected %0d, got %0d",
                           exp_rep.block_number, got.block_number);
                    n_errors++;
                end
                if (got.char_out !== exp_rep.char_out) begin
                    $error("char_out: expected %0h, got %0h",
                           exp_rep.char_out, got.char_out);
                    n_errors++;
                end
            end
            if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
            recv_stall = draw_gap(recv_burst);
            nxt_ready = (recv_stall == 0);
        end else if (!m_tready) begin
            if (recv_stall > 0) recv_stall--;
            if (recv_stall == 0) nxt_ready = 1'b1;
        end
        m_tready <= nxt_ready;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("** indexed_block_allocator_unit: FAILED **");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int n;
        int len;
        int pick;

        // directed: error paths, block skipping, reads, disk full
        push_write(5, 8'h11, 1'b0);
        push_write(0, 8'h22, 1'b1);
        push_write(7, 8'h33, 1'b0);
        push_write(3, 8'h00, 1'b1);
        push_write(9, 8'hff, 1'b0);
        push_write(2, 8'ha5, 1'b0);
        push_write(3, 8'h77, 1'b1);
        push_write(3, 8'h78, 1'b0);
        push_write(15, 8'h5a, 1'b1);
        push_read(3, 0);
        push_read(3, 2);
        push_read(15, 0);
        push_read(3, 15);
        push_read(0, 0);
        push_write(6, 8'h80, 1'b1);
        for (int i = 0; i < 8; i++) push_write(i, 8'h01 << i, 1'b0);
        push_read(6, 7);
        push_read(15, 15);

        // random: mostly whole files with random content, reads, some noise
        n = 0;
        while (n < RAND_REQS) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                len = ($urandom_range(0, 7) == 0) ? 18 : $urandom_range(0, 5);
                push_write(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15),
                           $urandom_range(0, 255), 1'b1);
                for (int i = 0; i < len; i++)
                    push_write($urandom_range(0, 15), $urandom_range(0, 255), 1'b0);
                n += len + 1;
            end else if (pick < 8) begin
                push_read($urandom_range(0, 15), $urandom_range(0, 15));
                n++;
            end else begin
                push_write($urandom_range(0, 15), $urandom_range(0, 255),
                           1'($urandom_range(0, 1)));
                n++;
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // wait until every request went out and every result came back
        do @(negedge aclk);
        while (request_queue.size() != 0 || s_tvalid || expected_replies.size() != 0);
        repeat (DRAIN) @(posedge aclk);

        if (n_errors == 0)
            $display("** indexed_block_allocator_unit: PASSED **");
        else
            $display("** indexed_block_allocator_unit: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
design/ibau_pkg.sv
design/ibau_free_search.sv
design/ibau_list_mem.sv
design/ibau_block_mem.sv
design/indexed_block_allocator_unit.sv
sim/indexed_block_allocator_unit_test.sv
